// ===== rtl/lcg_printable_shift_cipher_macros.svh =====
// ----------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the cipher queue.
// ----------------------------------------------------------------------
`ifndef LCG_PRINTABLE_SHIFT_CIPHER_MACROS_SVH
`define LCG_PRINTABLE_SHIFT_CIPHER_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define LCGPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition never occurs outside reset.
`define LCGPS_NEVER(lbl, cond, msg) \
    `LCGPS_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/lcgps_pkg.sv =====
// ----------------------------------------------------------------------
// Cipher package
// Codes, constants and shared types of the printable shift cipher.
// ----------------------------------------------------------------------
package lcgps_pkg;

    localparam logic [1:0] FUNC_RESTART = 2'd0;
    localparam logic [1:0] FUNC_ABSORB  = 2'd1;
    localparam logic [1:0] FUNC_ENCRYPT = 2'd2;
    localparam logic [1:0] FUNC_DECRYPT = 2'd3;

    localparam logic [1:0] CFG_PIN_FIRST  = 2'd0;
    localparam logic [1:0] CFG_PIN_SECOND = 2'd1;
    localparam logic [1:0] CFG_PIN_THIRD  = 2'd2;
    localparam logic [1:0] CFG_PIN_FOURTH = 2'd3;

    localparam logic [31:0] LCG_MUL      = 32'd1103515245;
    localparam logic [15:0] LCG_ADD      = 16'd12345;
    localparam logic [32:0] MIX_BASE     = 33'd1337;
    localparam logic [63:0] ZERO_KEY_SUB = 64'd123456789;
    localparam logic [7:0]  RING         = 8'd95;
    localparam logic [7:0]  LOW_PRINT    = 8'd32;
    localparam logic [7:0]  HIGH_PRINT   = 8'd126;

    // 256^i mod 95 for the six bytes of the 48-bit keystream word
    localparam int FOLD_TERMS = 6;
    localparam logic [6:0] FOLD_WEIGHT [FOLD_TERMS] = '{7'd1, 7'd66, 7'd81, 7'd26, 7'd6, 7'd16};

    // floor(2^22 / 95), quotient estimate low by at most one
    localparam logic [15:0] RECIP       = 16'd44150;
    localparam int          RECIP_SHIFT = 22;
    localparam int          QUOT_W      = 32 - RECIP_SHIFT;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_RESTART,
        KIND_ABSORB,
        KIND_CIPHER
    } item_kind_t;

    typedef struct packed {
        logic        decrypt;
        logic        printable;
        logic        reload;
        logic [7:0]  data_byte;
        logic [63:0] reload_seed;
    } cipher_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/lcgps_if.sv =====
// ----------------------------------------------------------------------
// Cipher channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------
interface lcgps_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       message_start;

    modport source (output valid, output func, output data_byte, output message_start,
                    input ready);
    modport sink (input valid, input func, input data_byte, input message_start,
                  output ready);
endinterface

interface lcgps_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       was_shifted;

    modport source (output valid, output out_byte, output was_shifted, input ready);
    modport sink (input valid, input out_byte, input was_shifted, output ready);
endinterface

// ===== rtl/lcgps_queue.sv =====
// ----------------------------------------------------------------------
// Cipher queue
// Short FIFO of classified cipher transactions between front and back.
// ----------------------------------------------------------------------
`include "lcg_printable_shift_cipher_macros.svh"

module lcgps_queue
    import lcgps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cipher_entry_t push_entry,
    input  logic          pop,
    output cipher_entry_t head,
    output queue_status_t status
);

    cipher_entry_t     slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_comb
    begin
        head         = slot_reg[rd_ptr_reg];
        status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
        status.empty = (count_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `LCGPS_NEVER(a_push_when_full, push && status.full, "queue push while full")
    `LCGPS_NEVER(a_pop_when_empty, pop && status.empty, "queue pop while empty")
    `LCGPS_ASSERT(a_count_up, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count did not advance")

endmodule

// ===== rtl/lcgps_front.sv =====
// ----------------------------------------------------------------------
// Cipher front end
// Accepts items, runs key restart and password mixing, and queues
// classified cipher transactions with their seed reload value.
// ----------------------------------------------------------------------
module lcgps_front
    import lcgps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lcgps_item_if.sink    item,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [3:0]    cfg_data,
    output logic          push,
    output cipher_entry_t push_entry,
    input  queue_status_t q_status
);

    logic [3:0]    pin_reg [4];
    logic [31:0]   index_reg;
    logic [63:0]   key_reg;
    logic          f_valid_reg;
    item_kind_t    f_kind_reg;
    logic [63:0]   f_val_reg;
    cipher_entry_t f_entry_reg;

    logic          accept;
    logic          f_adv;
    item_kind_t    kind_next;
    logic [63:0]   val_next;
    logic [31:0]   char_ext;
    logic [32:0]   weight;
    logic [13:0]   pin_key;
    logic [63:0]   mix_sum;

    always_comb
    begin
        char_ext = {{24{item.data_byte[7]}}, item.data_byte};
        weight   = {1'b0, index_reg} + MIX_BASE;
        pin_key  = 14'(pin_reg[CFG_PIN_FIRST])  * 14'd1000
                 + 14'(pin_reg[CFG_PIN_SECOND]) * 14'd200
                 + 14'(pin_reg[CFG_PIN_THIRD])  * 14'd30
                 + 14'(pin_reg[CFG_PIN_FOURTH]) * 14'd4;
        case (item.func)
            FUNC_RESTART: kind_next = KIND_RESTART;
            FUNC_ABSORB:  kind_next = KIND_ABSORB;
            default:      kind_next = KIND_CIPHER;
        endcase
        if (kind_next == KIND_RESTART)
        begin
            val_next = 64'(pin_key);
        end
        else
        begin
            val_next = {32'b0, char_ext} * {31'b0, weight};
        end

        f_adv      = !f_valid_reg || (f_kind_reg != KIND_CIPHER) || !q_status.full;
        item.ready = f_adv;
        accept     = item.valid && f_adv;

        mix_sum = key_reg + f_val_reg;

        push                   = f_valid_reg && (f_kind_reg == KIND_CIPHER) && !q_status.full;
        push_entry             = f_entry_reg;
        push_entry.reload_seed = (key_reg == '0) ? ZERO_KEY_SUB : key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pin_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            pin_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg   <= '0;
            key_reg     <= '0;
            f_valid_reg <= 1'b0;
            f_kind_reg  <= KIND_RESTART;
        end
        else
        begin
            if (accept)
            begin
                if (kind_next == KIND_RESTART)
                begin
                    index_reg <= '0;
                end
                else if (kind_next == KIND_ABSORB && index_reg != '1)
                begin
                    index_reg <= index_reg + 1'b1;
                end
            end
            if (f_valid_reg)
            begin
                if (f_kind_reg == KIND_RESTART)
                begin
                    key_reg <= f_val_reg;
                end
                else if (f_kind_reg == KIND_ABSORB)
                begin
                    key_reg <= mix_sum ^ (mix_sum << 5);
                end
            end
            if (f_adv)
            begin
                f_valid_reg <= accept;
                if (accept)
                begin
                    f_kind_reg <= kind_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_val_reg               <= val_next;
            f_entry_reg.decrypt     <= (item.func == FUNC_DECRYPT);
            f_entry_reg.printable   <= (item.data_byte >= LOW_PRINT)
                                       && (item.data_byte <= HIGH_PRINT);
            f_entry_reg.reload      <= item.message_start;
            f_entry_reg.data_byte   <= item.data_byte;
            f_entry_reg.reload_seed <= '0;
        end
    end

endmodule

// ===== rtl/lcgps_back.sv =====
// ----------------------------------------------------------------------
// Cipher back end
// Advances the keystream generator, reduces it modulo 95 over a short
// pipeline and shifts printable bytes within the ring.
// ----------------------------------------------------------------------
module lcgps_back
    import lcgps_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cipher_entry_t  head,
    input  queue_status_t  q_status,
    output logic           pop,
    lcgps_result_if.source result
);

    typedef struct packed {
        logic       decrypt;
        logic       printable;
        logic [7:0] data_byte;
    } byte_info_t;

    logic [63:0]       seed_reg;
    logic              p1_valid_reg;
    byte_info_t        p1_info_reg;
    logic [47:0]       p1_word_reg;
    logic              p2_valid_reg;
    byte_info_t        p2_info_reg;
    logic [15:0]       p2_y_reg;
    logic              p3_valid_reg;
    byte_info_t        p3_info_reg;
    logic [15:0]       p3_y_reg;
    logic [31:0]       p3_prod_reg;
    logic              p4_valid_reg;
    byte_info_t        p4_info_reg;
    logic [6:0]        p4_s_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_shifted_reg;

    logic              adv;
    logic [63:0]       seed_base;
    logic [63:0]       lo_prod;
    logic [31:0]       hi_prod;
    logic [63:0]       seed_next;
    logic [15:0]       fold_sum;
    logic [QUOT_W-1:0] quot;
    logic [15:0]       rem_wide;
    logic [7:0]        rem;
    logic [6:0]        shift_next;
    logic [7:0]        v_off;
    logic [7:0]        t_sum;
    logic [7:0]        t_mod;
    logic [7:0]        out_byte_next;

    always_comb
    begin
        adv = !out_valid_reg || result.ready;
        pop = adv && !q_status.empty;

        seed_base = head.reload ? head.reload_seed : seed_reg;
        lo_prod   = 64'(seed_base[31:0]) * 64'(LCG_MUL);
        hi_prod   = seed_base[63:32] * LCG_MUL;
        seed_next = lo_prod + {hi_prod, 32'b0} + 64'(LCG_ADD);

        fold_sum = '0;
        for (int i = 0; i < FOLD_TERMS; i++)
        begin
            fold_sum = fold_sum + 16'(p1_word_reg[8*i +: 8]) * 16'(FOLD_WEIGHT[i]);
        end

        quot       = p3_prod_reg[31:RECIP_SHIFT];
        rem_wide   = p3_y_reg - 16'(quot) * 16'(RING);
        rem        = rem_wide[7:0];
        shift_next = (rem >= RING) ? 7'(rem - RING) : rem[6:0];

        v_off = p4_info_reg.data_byte - LOW_PRINT;
        t_sum = v_off + (p4_info_reg.decrypt ? RING - {1'b0, p4_s_reg} : {1'b0, p4_s_reg});
        t_mod = (t_sum >= RING) ? t_sum - RING : t_sum;
        out_byte_next = p4_info_reg.printable ? t_mod + LOW_PRINT : p4_info_reg.data_byte;

        result.valid       = out_valid_reg;
        result.out_byte    = out_byte_reg;
        result.was_shifted = out_shifted_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (head.printable)
                begin
                    seed_reg <= seed_next;
                end
                else if (head.reload)
                begin
                    seed_reg <= head.reload_seed;
                end
            end
            if (adv)
            begin
                p1_valid_reg  <= pop;
                p2_valid_reg  <= p1_valid_reg;
                p3_valid_reg  <= p2_valid_reg;
                p4_valid_reg  <= p3_valid_reg;
                out_valid_reg <= p4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_info_reg     <= '{decrypt: head.decrypt, printable: head.printable,
                                 data_byte: head.data_byte};
            p1_word_reg     <= seed_next[63:16];
            p2_info_reg     <= p1_info_reg;
            p2_y_reg        <= fold_sum;
            p3_info_reg     <= p2_info_reg;
            p3_y_reg        <= p2_y_reg;
            p3_prod_reg     <= 32'(p2_y_reg) * 32'(RECIP);
            p4_info_reg     <= p3_info_reg;
            p4_s_reg        <= shift_next;
            out_byte_reg    <= out_byte_next;
            out_shifted_reg <= p4_info_reg.printable;
        end
    end

endmodule

// ===== rtl/lcg_printable_shift_cipher.sv =====
// ----------------------------------------------------------------------
// Printable shift cipher
// Byte stream cipher over printable ASCII with an LCG keystream.
// ----------------------------------------------------------------------
//  channel   dir   handshake      payload
//  item      in    valid/ready    func, data_byte, message_start
//  result    out   valid/ready    out_byte, was_shifted
//  cfg       in    cfg_we         cfg_index, cfg_data
//
//  One item per cycle unless a cipher item waits on a full queue;
//  restart and password items give no result. Bytes pass front, queue,
//  p1 to p4 and output registers; multiply-add and key mix are combinational.
//  Reset clears keys, seed, index and PIN registers at once; no sweep.
//  A stalled result holds the back pipeline; the queue lets the front
//  keep taking items until it fills.
// ----------------------------------------------------------------------
module lcg_printable_shift_cipher
    import lcgps_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    lcgps_item_if.sink     item,
    lcgps_result_if.source result,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [3:0]     cfg_data
);

    logic          push;
    logic          pop;
    cipher_entry_t push_entry;
    cipher_entry_t head;
    queue_status_t q_status;

    lcgps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_entry (push_entry),
        .q_status   (q_status)
    );

    lcgps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    lcgps_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

endmodule
